// File: rtl/rse_pkg.sv
// shared types and codes for the postfix stack evaluator
package rse_pkg;

    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 32;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W      = $clog2(DATA_W + 1);

    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [1:0]         cell_cmd_t;

    // token actions
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_APPLY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // operator codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_XOR = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_DIVZERO   = 2'd3;

    // cell commands: shift down takes the upper neighbor, shift up the lower one
    localparam cell_cmd_t CELL_HOLD     = 2'd0;
    localparam cell_cmd_t CELL_SHIFT_DN = 2'd1;
    localparam cell_cmd_t CELL_SHIFT_UP = 2'd2;

endpackage

// File: rtl/rse_cell.sv
// one stack cell: holds an entry and trades it with its neighbors
module rse_cell (
    input  logic             aclk,
    input  rse_pkg::cell_cmd_t cmd,
    input  rse_pkg::data_t   prev_data,
    input  rse_pkg::data_t   next_data,
    output rse_pkg::data_t   data
);
    import rse_pkg::*;

    data_t data_reg;
    data_t data_next;

    always_comb begin
        case (cmd)
            CELL_SHIFT_DN: data_next = prev_data;
            CELL_SHIFT_UP: data_next = next_data;
            default:       data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/rse_divider.sv
// iterative signed divider, one quotient bit per cycle, truncating
module rse_divider (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  rse_pkg::data_t dividend,
    input  rse_pkg::data_t divisor,
    output logic           done,
    output rse_pkg::data_t quotient
);
    import rse_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    step_t             step_reg, step_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    data_t             quo_reg, quo_next;
    data_t             dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    data_t             q_reg, q_next;
    logic [DATA_W:0]   shifted;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        shifted   = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = step_t'(DATA_W);
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? data_t'(-dividend) : dividend;
            dvs_next  = divisor[DATA_W-1] ? data_t'(-divisor) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end else if (busy_reg) begin
            if (step_reg != '0) begin
                // restoring step
                if (shifted >= {1'b0, dvs_reg}) begin
                    rem_next = shifted - {1'b0, dvs_reg};
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = shifted;
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                step_next = step_reg - step_t'(1);
            end else begin
                q_next    = neg_reg ? data_t'(-quo_reg) : quo_reg;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        q_reg    <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/rpn_stack_evaluator.sv
// top level: postfix token evaluator on a shifting chain of stack cells
// sequence: push, clear and idle tokens go through S_EXEC then S_DONE; operators
//   add S_OP and S_WRITE, an unknown operator may add S_DROP, a divide adds S_DIV (not on a zero divisor)
// throughput: one token at a time; the iterative divider (one bit per cycle) sets
//   the worst case per token, plus any stall on the result side
// reset: synchronous active-low aresetn empties the stack and drops any pending beat
module rpn_stack_evaluator (
    input  logic        aclk,
    input  logic        aresetn,
    // input token channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[1:0], operand_value[33:2], operator_code[36:34]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // top_value[31:0], stack_depth[37:32], status[39:38]
);
    import rse_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a token
    localparam logic [2:0] S_EXEC  = 3'd1;  // push / clear, or fetch operands
    localparam logic [2:0] S_OP    = 3'd2;  // alu or divider launch
    localparam logic [2:0] S_DIV   = 3'd3;  // divider running
    localparam logic [2:0] S_WRITE = 3'd4;  // update the cell chain
    localparam logic [2:0] S_DROP  = 3'd5;  // second pop for an unknown operator
    localparam logic [2:0] S_DONE  = 3'd6;  // hand result to the output register

    logic [2:0]  state_reg, state_next;
    logic [1:0]  action_reg, action_next;
    data_t       value_reg, value_next;
    logic [2:0]  opcode_reg, opcode_next;
    data_t       lhs_reg, lhs_next;
    data_t       rhs_reg, rhs_next;
    data_t       res_reg, res_next;
    logic [1:0]  status_reg, status_next;
    count_t      count_reg, count_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    // cell chain control
    cell_cmd_t   chain_cmd;
    logic        top_load;
    data_t       wr_value;
    data_t       cell_data [STACK_DEPTH];

    // divider hookup
    logic        div_start;
    logic        div_done;
    data_t       div_q;

    logic        store_op;
    data_t       top_value;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // opcodes past xor pop both operands and push nothing
    assign store_op  = (opcode_reg <= OP_XOR);
    assign top_value = (count_reg != '0) ? cell_data[0] : '0;

    // cell 0 is the stack top; a push shifts everything one cell deeper
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            data_t     prev_d;
            data_t     next_d;
            cell_cmd_t cmd_i;
            if (gi == 0) begin : g_top
                assign prev_d = wr_value;
                assign cmd_i  = top_load ? CELL_SHIFT_DN : chain_cmd;
            end else begin : g_mid
                assign prev_d = cell_data[gi-1];
                assign cmd_i  = chain_cmd;
            end
            if (gi == STACK_DEPTH - 1) begin : g_bot
                // bottom cell has no lower neighbor; its old value is never read
                assign next_d = cell_data[gi];
            end else begin : g_up
                assign next_d = cell_data[gi+1];
            end
            rse_cell u_cell (
                .aclk      (aclk),
                .cmd       (cmd_i),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    rse_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lhs_reg),
        .divisor  (rhs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next    = state_reg;
        action_next   = action_reg;
        value_next    = value_reg;
        opcode_next   = opcode_reg;
        lhs_next      = lhs_reg;
        rhs_next      = rhs_reg;
        res_next      = res_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        chain_cmd     = CELL_HOLD;
        top_load      = 1'b0;
        wr_value      = res_reg;
        div_start     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    action_next = s_tdata[1:0];
                    value_next  = s_tdata[33:2];
                    opcode_next = s_tdata[36:34];
                    status_next = ST_OK;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (action_reg)
                    ACT_PUSH: begin
                        if (count_reg == count_t'(STACK_DEPTH)) begin
                            status_next = ST_OVERFLOW;
                        end else begin
                            chain_cmd  = CELL_SHIFT_DN;
                            wr_value   = value_reg;
                            count_next = count_reg + count_t'(1);
                        end
                    end
                    ACT_APPLY: begin
                        // missing operands read as zero
                        rhs_next = (count_reg >= count_t'(1)) ? cell_data[0] : '0;
                        lhs_next = (count_reg >= count_t'(2)) ? cell_data[1] : '0;
                        if (count_reg < count_t'(2)) begin
                            status_next = ST_UNDERFLOW;
                        end
                        state_next = S_OP;
                    end
                    ACT_CLEAR: begin
                        count_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_OP: begin
                state_next = S_WRITE;
                case (opcode_reg)
                    OP_ADD: res_next = lhs_reg + rhs_reg;
                    OP_SUB: res_next = lhs_reg - rhs_reg;
                    OP_MUL: res_next = lhs_reg * rhs_reg;
                    OP_XOR: res_next = lhs_reg ^ rhs_reg;
                    OP_DIV: begin
                        if (rhs_reg == '0) begin
                            // zero divisor beats underflow
                            res_next    = '0;
                            status_next = ST_DIVZERO;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default: res_next = '0;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    res_next   = div_q;
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                state_next = S_DONE;
                if (store_op) begin
                    // net effect of pop, pop, push: drop one entry and replace the top
                    top_load = 1'b1;
                    wr_value = res_reg;
                    if (count_reg >= count_t'(2)) begin
                        chain_cmd  = CELL_SHIFT_UP;
                        count_next = count_reg - count_t'(1);
                    end else begin
                        count_next = count_t'(1);
                    end
                end else if (count_reg >= count_t'(2)) begin
                    chain_cmd  = CELL_SHIFT_UP;
                    count_next = count_reg - count_t'(1);
                    state_next = S_DROP;
                end else begin
                    count_next = '0;
                end
            end
            S_DROP: begin
                chain_cmd  = CELL_SHIFT_UP;
                count_next = count_reg - count_t'(1);
                state_next = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {status_reg, count_reg, top_value};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        action_reg  <= action_next;
        value_reg   <= value_next;
        opcode_reg  <= opcode_next;
        lhs_reg     <= lhs_next;
        rhs_reg     <= rhs_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    // depth never runs past the cell chain
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= count_t'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a dropped push only happens on a full stack
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[39:38] == ST_OVERFLOW) |-> m_tdata[37:32] == count_t'(STACK_DEPTH))
        else $error("overflow reported below full depth");

    // empty stack reports a zero top
    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[37:32] == '0) |-> m_tdata[31:0] == '0)
        else $error("nonzero top on empty stack");

    // divider finishes only while the sequencer waits on it
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider done outside divide wait");
`endif

endmodule
